FILE: rtl/stli_pkg.sv
// ----------------------------------------------------------------------------
// stli_pkg: shared constants and table builder for the sine lookup core
// Holds the fixed-point constants of the angle scaling and the function that
// computes one sine table entry at elaboration time.
// ----------------------------------------------------------------------------
package stli_pkg;

  // 2*pi in Q4.60, 1/(2*pi) in Q0.32, pi/2 in Q2.32, one in Q30.
  localparam logic [63:0] TWO_PI_Q60     = 64'h6487ED5110B4611A;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'h28BE60DB;
  localparam logic [63:0] HALF_PI_Q32    = 64'h00000001921FB544;
  localparam logic [63:0] ONE_Q30        = 64'h0000000040000000;

  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned SINE_W  = 16;

  // Entry for turn fraction u (Q0.32). The Taylor series is evaluated by
  // Horner steps with floored divisions, then rounded to Q1.15.
  function automatic logic signed [15:0] sine_entry(input logic [63:0] u);
    logic [1:0]  quad;
    logic [63:0] w;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] v;
    quad = u[31:30];
    w    = {34'd0, u[29:0]};
    if (quad[0]) begin
      w = ONE_Q30 - w;
    end
    z  = (w * HALF_PI_Q32) >> 32;
    z2 = (z * z) >> 30;
    h  = ONE_Q30;
    h  = ONE_Q30 - (((z2 * h) >> 30) / 64'd156);
    h  = ONE_Q30 - (((z2 * h) >> 30) / 64'd110);
    h  = ONE_Q30 - (((z2 * h) >> 30) / 64'd72);
    h  = ONE_Q30 - (((z2 * h) >> 30) / 64'd42);
    h  = ONE_Q30 - (((z2 * h) >> 30) / 64'd20);
    h  = ONE_Q30 - (((z2 * h) >> 30) / 64'd6);
    s  = (z * h) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    if (quad[1]) begin
      return $signed(16'(~v[15:0] + 16'd1));
    end
    return $signed(v[15:0]);
  endfunction

endpackage

FILE: rtl/stli_rom.sv
// ----------------------------------------------------------------------------
// stli_rom: sine sample table with two registered read ports
// The samples cover 0 to 2*pi with both ends included; the contents are
// fixed when the design is built.
// ----------------------------------------------------------------------------
module stli_rom #(
  parameter int unsigned TABLE_SAMPLES = 1025
) (
  input  logic                                   clk,
  input  logic [$clog2(TABLE_SAMPLES)-1:0]       rd0_addr,
  input  logic [$clog2(TABLE_SAMPLES)-1:0]       rd1_addr,
  output logic signed [stli_pkg::SINE_W-1:0]     rd0_data,
  output logic signed [stli_pkg::SINE_W-1:0]     rd1_data
);
  import stli_pkg::*;

  localparam int unsigned SPAN = TABLE_SAMPLES - 1;

  logic signed [SINE_W-1:0] rom_w [TABLE_SAMPLES];
  logic signed [SINE_W-1:0] rd0_r;
  logic signed [SINE_W-1:0] rd1_r;

  for (genvar g = 0; g < TABLE_SAMPLES; g++) begin : g_entry
    localparam logic [63:0] TURN = ((64'(g) << 32) + 64'(SPAN / 2)) / 64'(SPAN);
    assign rom_w[g] = sine_entry(TURN);
  end

  always_ff @(posedge clk) begin
    rd0_r <= rom_w[rd0_addr];
    rd1_r <= rom_w[rd1_addr];
  end

  assign rd0_data = rd0_r;
  assign rd1_data = rd1_r;

endmodule

FILE: rtl/sine_table_linear_interpolation_core.sv
// ----------------------------------------------------------------------------
// sine_table_linear_interpolation_core: sine of a Q4.28 angle by table lookup
// One request is taken every cycle, so busy stays low. The six register stages
// (two scaling multiplies, table read, difference, blend multiply, round) set
// the latency. Reset clears the stage valid bits and the strobe.
// ----------------------------------------------------------------------------
module sine_table_linear_interpolation_core #(
  parameter int unsigned TABLE_SAMPLES   = 1025,
  parameter int unsigned ANGLE_FRAC_BITS = 28
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [stli_pkg::ANGLE_W-1:0]   in_angle,
  output logic                                  out_valid,
  output logic signed [stli_pkg::SINE_W-1:0]    out_sine_value
);
  import stli_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SAMPLES);
  localparam int unsigned P_W   = 32 + IDX_W;
  localparam int unsigned PROD_W = 61;
  localparam logic [IDX_W-1:0] SPAN    = IDX_W'(TABLE_SAMPLES - 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_SAMPLES - 2);
  localparam logic signed [ANGLE_W-1:0] TOP_ANGLE =
    $signed(ANGLE_W'(TWO_PI_Q60 >> (60 - ANGLE_FRAC_BITS)));

  // Stage 1: angle times 1/(2*pi).
  logic                s1_valid_r;
  logic                s1_zero_r;
  logic [PROD_W-1:0]   s1_prod_r;
  // Stage 2: turn fraction times table span.
  logic                s2_valid_r;
  logic                s2_zero_r;
  logic [P_W-1:0]      s2_p_r;
  // Stage 3: table read in flight.
  logic                s3_valid_r;
  logic                s3_zero_r;
  logic [15:0]         s3_frac_r;
  // Stage 4: neighbor difference.
  logic                s4_valid_r;
  logic                s4_zero_r;
  logic [15:0]         s4_frac_r;
  logic signed [SINE_W-1:0] s4_base_r;
  logic signed [SINE_W:0]   s4_diff_r;
  // Stage 5: blend product.
  logic                s5_valid_r;
  logic                s5_zero_r;
  logic signed [SINE_W-1:0]   s5_base_r;
  logic signed [2*SINE_W+1:0] s5_prod_r;
  // Output.
  logic                out_valid_r;
  logic signed [SINE_W-1:0] out_sine_r;
  logic signed [SINE_W-1:0] out_sine_nxt;

  logic                accept;
  logic                in_zero;
  logic [31:0]         turn;
  logic [IDX_W-1:0]    idx_raw;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    idx_next;
  logic signed [SINE_W-1:0] rom_v0;
  logic signed [SINE_W-1:0] rom_v1;
  logic signed [2*SINE_W+1:0] rounded;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Angles at or below zero, or past 2*pi, produce zero.
  assign in_zero = (in_angle <= $signed(32'sd0)) || (in_angle > TOP_ANGLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  assign turn     = s1_prod_r[ANGLE_FRAC_BITS +: 32];
  assign idx_raw  = s2_p_r[32 +: IDX_W];
  assign idx      = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
  assign idx_next = idx + IDX_W'(1);

  stli_rom #(
    .TABLE_SAMPLES(TABLE_SAMPLES)
  ) u_rom (
    .clk      (clk),
    .rd0_addr (idx),
    .rd1_addr (idx_next),
    .rd0_data (rom_v0),
    .rd1_data (rom_v1)
  );

  // floor((v0*2^16 + d*f + 2^15) / 2^16) equals v0 + floor((d*f + 2^15) / 2^16).
  assign rounded = (s5_prod_r + (2*SINE_W+2)'(32768)) >>> 16;

  always_comb begin
    out_sine_nxt = s5_base_r + rounded[SINE_W-1:0];
    if (s5_zero_r) begin
      out_sine_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    s1_zero_r  <= in_zero;
    s1_prod_r  <= PROD_W'(in_angle[30:0]) * PROD_W'(INV_TWO_PI_Q32);

    s2_zero_r  <= s1_zero_r;
    s2_p_r     <= P_W'(turn) * P_W'(SPAN);

    s3_zero_r  <= s2_zero_r;
    s3_frac_r  <= s2_p_r[31:16];

    s4_zero_r  <= s3_zero_r;
    s4_frac_r  <= s3_frac_r;
    s4_base_r  <= rom_v0;
    s4_diff_r  <= (SINE_W+1)'(rom_v1) - (SINE_W+1)'(rom_v0);

    s5_zero_r  <= s4_zero_r;
    s5_base_r  <= s4_base_r;
    s5_prod_r  <= (2*SINE_W+2)'(s4_diff_r) *
                  (2*SINE_W+2)'($signed({1'b0, s4_frac_r}));

    out_sine_r <= out_sine_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sine_value = out_sine_r;

endmodule
